[rtl/bcri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-coded register ALU interpreter package
// Shared types, constants and helpers for the interpreter core.
// ----------------------------------------------------------------------------
package bcri_pkg;

  localparam int RegBase   = 48;
  localparam int SpaceSize = 256;
  localparam int RegCount  = (SpaceSize > RegBase) ? (SpaceSize - RegBase) : 0;
  localparam int RegDepth  = (RegCount > 1) ? RegCount : 2;
  localparam int RegIdxW   = $clog2(RegDepth);
  localparam bit RegPresent = (RegCount > 0);

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [7:0] {
    OP_LDI = 8'h01,
    OP_ADD = 8'h02,
    OP_SUB = 8'h03,
    OP_AND = 8'h04,
    OP_OR  = 8'h05,
    OP_XOR = 8'h06,
    OP_MOV = 8'h07,
    OP_NEG = 8'h08,
    OP_NOT = 8'h09,
    OP_RET = 8'h0A
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_RET       = 2'd0,
    CAUSE_CODE_END  = 2'd1,
    CAUSE_BAD_OP    = 2'd2,
    CAUSE_RET_RANGE = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RET   = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [7:0] value;
    cause_e            end_cause;
  } out_t;

  typedef struct packed {
    cmd_e               kind;
    op_e                alu;
    logic [RegIdxW-1:0] addr_a;
    logic [RegIdxW-1:0] addr_b;
    logic [7:0]         imm;
    logic               finish;
    cause_e             cause;
  } cmd_t;

  function automatic logic in_range(logic [7:0] idx);
    return {1'b0, idx} < 9'(RegCount);
  endfunction

  function automatic logic [RegIdxW-1:0] to_idx(logic [7:0] idx);
    return idx[RegIdxW-1:0];
  endfunction

endpackage

[rtl/bcri_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter front end
// Accepts items, parses code bytes into instructions and issues commands.
// ----------------------------------------------------------------------------
module bcri_front import bcri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  input  logic q_full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] op_q, op_d;
  logic [7:0] first_q, first_d;
  logic       halted_q, halted_d;
  logic       accept;
  logic [7:0] byte_in;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign byte_in    = in_data_i.data;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    first_d  = first_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    cmd_o.kind   = CMD_END;
    cmd_o.alu    = op_e'(op_q);
    cmd_o.addr_a = to_idx(first_q);
    cmd_o.addr_b = to_idx(byte_in);
    cmd_o.imm    = byte_in;
    cmd_o.finish = in_data_i.last;
    cmd_o.cause  = CAUSE_CODE_END;
    if (accept) begin
      if (!in_data_i.operation) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_START;
        phase_d    = PH_OPCODE;
        op_d       = '0;
        first_d    = '0;
        halted_d   = in_data_i.last;
      end else if (!halted_q) begin
        unique case (phase_q)
          PH_FIRST: begin
            phase_d = PH_OPCODE;
            if (op_q == OP_RET) begin
              push_o       = 1'b1;
              halted_d     = 1'b1;
              cmd_o.finish = 1'b1;
              if (in_range(byte_in)) begin
                cmd_o.kind   = CMD_RET;
                cmd_o.addr_a = to_idx(byte_in);
                cmd_o.cause  = CAUSE_RET;
              end else begin
                cmd_o.cause = CAUSE_RET_RANGE;
              end
            end else if (op_q == OP_NEG || op_q == OP_NOT) begin
              halted_d = in_data_i.last;
              if (in_range(byte_in)) begin
                push_o       = 1'b1;
                cmd_o.kind   = CMD_WRITE;
                cmd_o.addr_a = to_idx(byte_in);
              end else begin
                push_o = in_data_i.last;
              end
            end else begin
              first_d = byte_in;
              if (in_data_i.last) begin
                push_o   = 1'b1;
                halted_d = 1'b1;
              end else begin
                phase_d = PH_SECOND;
              end
            end
          end
          PH_SECOND: begin
            phase_d  = PH_OPCODE;
            halted_d = in_data_i.last;
            if (in_range(first_q) && (op_q == OP_LDI || in_range(byte_in))) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_WRITE;
            end else begin
              push_o = in_data_i.last;
            end
          end
          default: begin
            if (byte_in < OP_LDI || byte_in > OP_RET) begin
              push_o       = 1'b1;
              halted_d     = 1'b1;
              cmd_o.finish = 1'b1;
              cmd_o.cause  = CAUSE_BAD_OP;
            end else begin
              op_d = byte_in;
              if (in_data_i.last) begin
                push_o   = 1'b1;
                halted_d = 1'b1;
              end else begin
                phase_d = PH_FIRST;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      op_q     <= '0;
      first_q  <= '0;
      halted_q <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      first_q  <= first_d;
      halted_q <= halted_d;
    end
  end

endmodule

[rtl/bcri_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small register FIFO that decouples the front end from the execution side.
// ----------------------------------------------------------------------------
module bcri_queue import bcri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

[rtl/bcri_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter back end
// Reads the register file, executes commands and holds the result register.
// ----------------------------------------------------------------------------
module bcri_back import bcri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [7:0]          mem_q [RegDepth];
  logic [7:0]          rd_a_q, rd_b_q;
  logic [RegDepth-1:0] valid_q, valid_d;
  logic                fa_q, fb_q;
  logic [7:0]          fwd_q;
  cmd_t                e_q;
  logic                e_vld_q;
  logic                out_vld_q;
  out_t                out_q;

  logic               e_adv, e_fire;
  logic               wr_en;
  logic [RegIdxW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         x, y, alu_res;

  assign e_adv  = ~(e_vld_q & e_q.finish & out_vld_q & ~out_ready_i);
  assign e_fire = e_vld_q & e_adv;
  assign pop_o  = q_valid_i & e_adv;

  assign x = fa_q ? fwd_q : (valid_q[e_q.addr_a] ? rd_a_q : 8'h00);
  assign y = fb_q ? fwd_q : (valid_q[e_q.addr_b] ? rd_b_q : 8'h00);

  always_comb begin
    unique case (e_q.alu)
      OP_LDI:  alu_res = e_q.imm;
      OP_ADD:  alu_res = x + y;
      OP_SUB:  alu_res = x - y;
      OP_AND:  alu_res = x & y;
      OP_OR:   alu_res = x | y;
      OP_XOR:  alu_res = x ^ y;
      OP_MOV:  alu_res = y;
      OP_NEG:  alu_res = 8'h00 - x;
      OP_NOT:  alu_res = ~x;
      default: alu_res = x;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = e_q.addr_a;
    wr_data = alu_res;
    valid_d = valid_q;
    if (e_fire) begin
      unique case (e_q.kind)
        CMD_START: begin
          valid_d = '0;
          wr_addr = '0;
          wr_data = e_q.imm;
          if (RegPresent) begin
            wr_en      = 1'b1;
            valid_d[0] = 1'b1;
          end
        end
        CMD_WRITE: begin
          wr_en               = 1'b1;
          valid_d[e_q.addr_a] = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (pop_o) begin
      rd_a_q <= mem_q[q_cmd_i.addr_a];
      rd_b_q <= mem_q[q_cmd_i.addr_b];
      fwd_q  <= wr_data;
      e_q    <= q_cmd_i;
    end
    if (e_fire && e_q.finish) begin
      out_q.value     <= (e_q.kind == CMD_RET) ? x : 8'sh00;
      out_q.end_cause <= e_q.cause;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fa_q      <= 1'b0;
      fb_q      <= 1'b0;
      e_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        fa_q <= wr_en & (wr_addr == q_cmd_i.addr_a);
        fb_q <= wr_en & (wr_addr == q_cmd_i.addr_b);
      end
      if (e_adv) begin
        e_vld_q <= q_valid_i;
      end
      if (e_fire && e_q.finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[rtl/bytecode_register_alu_interpreter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-coded register ALU interpreter core
// Runs byte-coded programs against a file of 8-bit registers.
//
// The input channel takes one item per cycle while the queue has room: a
// start item (operation 0) clears the registers and loads its data byte into
// register 0, and code items (operation 1) carry one program byte each. The
// output channel gives one item per finished run with the returned value and
// the end cause. The front end parses bytes and pushes commands into a
// four-entry queue; the back end reads two registers, executes and writes one
// per cycle unless a held result stalls it. The item that ends the run passes
// through the queue and the execute register into the result register. Without
// stalls, throughput is one input item per cycle, set by the single write port
// of the register file and the one-command-per-cycle back end. Reset leaves
// the core waiting for a start item with an empty queue and all registers
// reading zero. When the receiver stalls, the back end holds its result, the
// queue fills, and input ready falls only once the queue is full.
// ----------------------------------------------------------------------------
module bytecode_register_alu_interpreter_core import bcri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic push, q_full, pop, q_valid;
  cmd_t cmd_in, cmd_head;

  bcri_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  bcri_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_head)
  );

  bcri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
